[sv/perturbed_distance_error_sum_unit_defines.svh]
// assertion macros used by the top-level rtl file
`ifndef PERTURBED_DISTANCE_ERROR_SUM_UNIT_DEFINES_SVH
`define PERTURBED_DISTANCE_ERROR_SUM_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PDES_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PDES_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PDES_ASSERT(name, prop, msg)
`define PDES_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

[sv/pdes_pkg.sv]
`default_nettype none
package pdes_pkg;

  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // register index, taken from the word address bit
  localparam logic REG_STEP_SIZE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_D2,
    ST_MUL_P,
    ST_RAD,
    ST_SQRT,
    ST_DIFF,
    ST_MUL_E,
    ST_ACC
  } state_e;

  typedef struct packed {
    logic load;
    logic cap_d2;
    logic cap_p;
    logic rad_init;
    logic sqrt_step;
    logic cap_diff;
    logic cap_e;
    logic acc;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic last;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

[sv/pdes_ctrl.sv]
`default_nettype none
module pdes_ctrl import pdes_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  status_t status_i,
  output logic    in_stall_o,
  output cmd_t    cmd_o
);

  localparam int unsigned CNT_W = $clog2(WORD_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic emit_blocked;

  // a closing transaction waits while the previous sum is still unread
  assign emit_blocked = status_i.last && status_i.out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MUL_D2;
      end
      ST_MUL_D2: begin
        if (status_i.skip) state_d = ST_ACC;
        else state_d = ST_MUL_P;
      end
      ST_MUL_P: state_d = ST_RAD;
      ST_RAD: begin
        state_d = ST_SQRT;
        cnt_d   = '0;
      end
      ST_SQRT: begin
        if (cnt_q == CNT_LAST) state_d = ST_DIFF;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_DIFF:  state_d = ST_MUL_E;
      ST_MUL_E: state_d = ST_ACC;
      ST_ACC: begin
        if (!emit_blocked) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    in_stall_o      = (state_q != ST_IDLE);
    cmd_o.load      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.cap_d2    = (state_q == ST_MUL_D2);
    cmd_o.cap_p     = (state_q == ST_MUL_P);
    cmd_o.rad_init  = (state_q == ST_RAD);
    cmd_o.sqrt_step = (state_q == ST_SQRT);
    cmd_o.cap_diff  = (state_q == ST_DIFF);
    cmd_o.cap_e     = (state_q == ST_MUL_E);
    cmd_o.acc       = (state_q == ST_ACC) && !emit_blocked;
  end

endmodule
`default_nettype wire

[sv/pdes_dpath.sv]
`default_nettype none
module pdes_dpath import pdes_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  input  logic [WORD_BITS-1:0] step_i,
  input  logic [FIELD_W-1:0]   dist_now_i,
  input  logic [FIELD_W-1:0]   dist_goal_i,
  input  logic [FIELD_W-1:0]   own_coord_i,
  input  logic [FIELD_W-1:0]   other_coord_i,
  input  logic                 skip_item_i,
  input  logic                 last_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SUM_W-1:0]     error_sum_o
);

  localparam int unsigned W      = WORD_BITS;
  localparam int unsigned DW     = 2 * WORD_BITS;
  localparam int unsigned MUL_W  = WORD_BITS + 2;
  localparam int unsigned PROD_W = 2 * MUL_W;

  logic [W-1:0]    dnow_q, dgoal_q, own_q, other_q;
  logic            skip_q, last_q;
  logic [W-1:0]    sm_q;
  logic [W+1:0]    qm_q;
  logic            neg_q;
  logic [DW-1:0]   d2_q;
  logic [DW+1:0]   p_q;
  logic [DW-1:0]   rad_q;
  logic [W+1:0]    rem_q;
  logic [W-1:0]    root_q;
  logic [W-1:0]    diff_q;
  logic [DW-1:0]   e_q;
  logic [DW-1:0]   sum_q;
  logic [DW-1:0]   out_q;
  logic            out_valid_q;

  // gap and step terms, two's complement
  logic [W:0]      gap;
  logic [W+2:0]    sum2;
  logic [W+2:0]    sum2_abs;
  logic [W-1:0]    step_abs;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;

  logic [DW+1:0]   rad_lo;
  logic [DW-1:0]   rad;

  logic [W+1:0]    rem_sh;
  logic [W+1:0]    trial;
  logic            take;

  logic [DW:0]     sum_add;
  logic [DW-1:0]   sum_new;

  assign gap      = {own_q[W-1], own_q} - {other_q[W-1], other_q};
  assign sum2     = {gap[W], gap, 1'b0} + {{3{step_i[W-1]}}, step_i};
  assign sum2_abs = sum2[W+2] ? (~sum2 + 1'b1) : sum2;
  assign step_abs = step_i[W-1] ? (~step_i + 1'b1) : step_i;

  // one shared multiplier, operands picked by the active step
  always_comb begin
    priority if (cmd_i.cap_p) begin
      mul_a = MUL_W'(sm_q);
      mul_b = qm_q;
    end else if (cmd_i.cap_e) begin
      mul_a = MUL_W'(diff_q);
      mul_b = MUL_W'(diff_q);
    end else begin
      mul_a = MUL_W'(dnow_q);
      mul_b = MUL_W'(dnow_q);
    end
  end
  assign prod = mul_a * mul_b;

  // radicand: d^2 plus or minus step*(2*gap+step), clamped both ways
  assign rad_lo = {2'b00, d2_q} + p_q;
  always_comb begin
    if (!neg_q) begin
      rad = (rad_lo[DW+1:DW] != 2'b00) ? {DW{1'b1}} : rad_lo[DW-1:0];
    end else if (p_q > {2'b00, d2_q}) begin
      rad = '0;
    end else begin
      rad = d2_q - p_q[DW-1:0];
    end
  end

  // restoring root, one result bit per cycle
  assign rem_sh = {rem_q[W-1:0], rad_q[DW-1:DW-2]};
  assign trial  = {root_q, 2'b01};
  assign take   = (rem_sh >= trial);

  assign sum_add = {1'b0, sum_q} + {1'b0, e_q};
  always_comb begin
    if (skip_q) sum_new = sum_q;
    else if (sum_add[DW]) sum_new = {DW{1'b1}};
    else sum_new = sum_add[DW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dnow_q  <= dist_now_i[W-1:0];
      dgoal_q <= dist_goal_i[W-1:0];
      own_q   <= own_coord_i[W-1:0];
      other_q <= other_coord_i[W-1:0];
      skip_q  <= skip_item_i;
      last_q  <= last_item_i;
    end
    if (cmd_i.cap_d2) begin
      d2_q  <= prod[DW-1:0];
      sm_q  <= step_abs;
      qm_q  <= sum2_abs[W+1:0];
      neg_q <= step_i[W-1] ^ sum2[W+2];
    end
    if (cmd_i.cap_p) p_q <= prod[DW+1:0];
    if (cmd_i.rad_init) begin
      rad_q  <= rad;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[DW-3:0], 2'b00};
      rem_q  <= take ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[W-2:0], take};
    end
    if (cmd_i.cap_diff) begin
      diff_q <= (dgoal_q >= root_q) ? (dgoal_q - root_q) : (root_q - dgoal_q);
    end
    if (cmd_i.cap_e) e_q <= prod[DW-1:0];
    if (cmd_i.acc && last_q) out_q <= sum_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.acc) sum_q <= last_q ? '0 : sum_new;
      if (cmd_i.acc && last_q) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign status_o.skip     = skip_q;
  assign status_o.last     = last_q;
  assign status_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign error_sum_o       = SUM_W'(out_q);

endmodule
`default_nettype wire

[sv/perturbed_distance_error_sum_unit.sv]
// a closing transaction passes the d^2, product, radicand, root, difference and square
// states and accumulate before error_sum_o is valid; a skipped one skips to accumulate
// input stalls until a transaction is done; the root unit settles one result bit per cycle
// the result sits in an output register, so a new transaction is taken while it waits
// reset clears the running sum, step_size and all control; no clearing pass
`default_nettype none
`include "perturbed_distance_error_sum_unit_defines.svh"
module perturbed_distance_error_sum_unit import pdes_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [FIELD_W-1:0]    dist_now_i,
  input  logic [FIELD_W-1:0]    dist_goal_i,
  input  logic [FIELD_W-1:0]    own_coord_i,
  input  logic [FIELD_W-1:0]    other_coord_i,
  input  logic                  skip_item_i,
  input  logic                  last_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SUM_W-1:0]      error_sum_o
);

  logic [WORD_BITS-1:0] step_q;
  logic                 step_we;
  logic                 reg_sel;
  cmd_t                 cmd;
  status_t              status;

  assign reg_sel = (paddr[APB_ADDR_W-1] == REG_STEP_SIZE);
  assign step_we = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? APB_DATA_W'(step_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (step_we) begin
      step_q <= pwdata[WORD_BITS-1:0];
    end
  end

  pdes_ctrl #(
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  pdes_dpath #(
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .step_i        (step_q),
    .dist_now_i    (dist_now_i),
    .dist_goal_i   (dist_goal_i),
    .own_coord_i   (own_coord_i),
    .other_coord_i (other_coord_i),
    .skip_item_i   (skip_item_i),
    .last_item_i   (last_item_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .error_sum_o   (error_sum_o)
  );

  `PDES_ASSERT(a_busy_in_root, cmd.sqrt_step |-> in_stall_o, "root step while input open")
  `PDES_ASSERT(a_emit_source, $rose(out_valid_o) |-> $past(cmd.acc && status.last), "stray result")
  `PDES_ASSERT_NEXT(a_one_at_a_time, cmd.load, !cmd.load, "back to back load")

endmodule
`default_nettype wire

[bench/tb.sv]
`default_nettype none
module tb import pdes_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROOT_LAT = FIELD_W + 7;
  localparam logic [APB_ADDR_W-1:0] ADDR_STEP = APB_ADDR_W'({REG_STEP_SIZE, 2'b00});

  typedef struct packed {
    logic [FIELD_W-1:0] dist_now;
    logic [FIELD_W-1:0] dist_goal;
    logic [FIELD_W-1:0] own_coord;
    logic [FIELD_W-1:0] other_coord;
    logic               skip_item;
    logic               last_item;
  } point_item_t;

  logic                  clk_i;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  wire  [APB_DATA_W-1:0] prdata;
  wire                   pready;
  logic                  in_valid;
  wire                   in_stall;
  logic [FIELD_W-1:0]    dist_now;
  logic [FIELD_W-1:0]    dist_goal;
  logic [FIELD_W-1:0]    own_coord;
  logic [FIELD_W-1:0]    other_coord;
  logic                  skip_item;
  logic                  last_item;
  wire                   out_valid;
  logic                  out_stall;
  wire  [SUM_W-1:0]      error_sum;

  // predictor state
  logic [FIELD_W-1:0] step_model;
  logic [SUM_W-1:0]   sum_model;
  logic [SUM_W-1:0]   exp_sums[$];

  int   fails;
  int   stall_left;
  int   guard;
  logic calm;
  logic out_hold;

  perturbed_distance_error_sum_unit #(
    .WORD_BITS(FIELD_W)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .dist_now_i   (dist_now),
    .dist_goal_i  (dist_goal),
    .own_coord_i  (own_coord),
    .other_coord_i(other_coord),
    .skip_item_i  (skip_item),
    .last_item_i  (last_item),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .error_sum_o  (error_sum)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("perturbed_distance_error_sum_unit: mismatch");
    $finish;
  end

  // floor of the square root, bit by bit from the top
  function automatic logic [FIELD_W-1:0] floor_root(input logic [SUM_W-1:0] rad);
    logic [FIELD_W-1:0] r;
    logic [FIELD_W-1:0] t;
    r = '0;
    for (int b = FIELD_W - 1; b >= 0; b--) begin
      t = r | (FIELD_W'(1) << b);
      if ({32'd0, t} * {32'd0, t} <= rad) r = t;
    end
    return r;
  endfunction

  function automatic logic [SUM_W-1:0] sq_error(input logic [FIELD_W-1:0] dnow,
                                                input logic [FIELD_W-1:0] dgoal,
                                                input logic [FIELD_W-1:0] own,
                                                input logic [FIELD_W-1:0] other,
                                                input logic [FIELD_W-1:0] step);
    longint              gap;
    longint              twice_plus;
    logic signed [127:0] d2_w;
    logic signed [127:0] step_w;
    logic signed [127:0] lin_w;
    logic signed [127:0] rad_w;
    logic [SUM_W-1:0]    rad;
    logic [FIELD_W-1:0]  root;
    logic [FIELD_W-1:0]  diff;
    gap        = longint'($signed(own)) - longint'($signed(other));
    twice_plus = 2 * gap + longint'($signed(step));
    d2_w       = $signed({64'd0, {32'd0, dnow} * {32'd0, dnow}});
    step_w     = longint'($signed(step));
    lin_w      = twice_plus;
    // new gap squared minus old gap squared is step * (2 * gap + step)
    rad_w      = d2_w + step_w * lin_w;
    if (rad_w < 0) rad = '0;
    else if (rad_w[127:64] != '0) rad = '1;
    else rad = rad_w[63:0];
    root = floor_root(rad);
    diff = (dgoal >= root) ? dgoal - root : root - dgoal;
    return {32'd0, diff} * {32'd0, diff};
  endfunction

  task automatic predict_item(input point_item_t it);
    logic [SUM_W:0] s;
    if (!it.skip_item) begin
      s = {1'b0, sum_model} +
          {1'b0, sq_error(it.dist_now, it.dist_goal, it.own_coord, it.other_coord,
                          step_model)};
      sum_model = s[SUM_W] ? '1 : s[SUM_W-1:0];
    end
    if (it.last_item) begin
      exp_sums.push_back(sum_model);
      sum_model = '0;
    end
  endtask

  task automatic idle_input(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_item(input point_item_t it);
    if (!calm && $urandom_range(0, 3) == 0) idle_input($urandom_range(1, 17));
    in_valid    <= 1'b1;
    dist_now    <= it.dist_now;
    dist_goal   <= it.dist_goal;
    own_coord   <= it.own_coord;
    other_coord <= it.other_coord;
    skip_item   <= it.skip_item;
    last_item   <= it.last_item;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predict_item(it);
  endtask

  task automatic send_fields(input logic [FIELD_W-1:0] dn, input logic [FIELD_W-1:0] dg,
                             input logic [FIELD_W-1:0] ow, input logic [FIELD_W-1:0] ot,
                             input logic sk, input logic la);
    point_item_t it;
    it = '{dn, dg, ow, ot, sk, la};
    send_item(it);
  endtask

  // no result comes from a non-closing transaction, so allow the root unit to finish
  task automatic wait_drained();
    idle_input(1);
    while (exp_sums.size() != 0) @(posedge clk_i);
    repeat (2 * ROOT_LAT) @(posedge clk_i);
  endtask

  task automatic write_step(input logic [FIELD_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_STEP;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    step_model = value;
  endtask

  function automatic point_item_t make_point(input bit wide);
    point_item_t it;
    if (wide) begin
      it.dist_now    = $urandom;
      it.dist_goal   = $urandom;
      it.own_coord   = $urandom;
      it.other_coord = $urandom;
    end else begin
      // plausible geometry, within about +-64.0
      it.dist_now    = $urandom_range(0, 32'h80_0000);
      it.dist_goal   = $urandom_range(0, 32'h80_0000);
      it.own_coord   = FIELD_W'($urandom_range(0, 32'h80_0000)) - 32'h40_0000;
      it.other_coord = FIELD_W'($urandom_range(0, 32'h80_0000)) - 32'h40_0000;
    end
    it.skip_item = 1'b0;
    it.last_item = 1'b0;
    return it;
  endfunction

  task automatic run_random_rows(input int n_items);
    point_item_t it;
    int          sent;
    int          len;
    int          skip_at;
    bit          wide;
    bit          noisy;
    sent = 0;
    while (sent < n_items) begin
      len     = $urandom_range(1, 12);
      skip_at = $urandom_range(0, len);
      wide    = ($urandom_range(0, 3) == 0);
      noisy   = ($urandom_range(0, 6) == 0);
      for (int k = 0; k < len; k++) begin
        it = make_point(wide);
        if (noisy) begin
          it.skip_item = ($urandom_range(0, 3) == 0);
          it.last_item = ($urandom_range(0, 3) == 0);
        end else begin
          it.skip_item = (k == skip_at);
          it.last_item = (k == len - 1);
        end
        send_item(it);
      end
      sent += len;
    end
  endtask

  function automatic logic [FIELD_W-1:0] pick_step(input int p);
    case (p % 6)
      0:       return $urandom_range(1, 32'h2_0000);
      1:       return FIELD_W'(0) - FIELD_W'($urandom_range(1, 32'h2_0000));
      2:       return $urandom;
      3:       return FIELD_W'($urandom_range(0, 32'h10_0000)) - 32'h8_0000;
      4:       return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_step();
    send_fields(32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
    send_fields(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1);
    // two full-scale errors saturate the sum
    send_fields(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
    send_fields(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1, 1'b0, 1'b0);
    send_fields(32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 1'b1);
    // skipped closing transaction emits the sum as it stands
    send_fields(32'h5_0000, 32'h5_0000, 32'h0, 32'h0, 1'b1, 1'b1);
  endtask

  task automatic test_step_extremes();
    wait_drained();
    write_step(32'h7FFF_FFFF);
    send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1);
    send_fields(32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
    wait_drained();
    write_step(32'h8000_0000);
    send_fields(32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1);
    // radicand goes negative and clamps
    send_fields(32'h1_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b1);
    // 2*gap + step is zero
    send_fields(32'hFFFF_FFFF, 32'h0, 32'h4000_0000, 32'h0, 1'b0, 1'b1);
  endtask

  task automatic test_root_truncation();
    wait_drained();
    write_step(32'h1);
    send_fields(32'h3_0000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
    wait_drained();
    write_step(32'hFFFF_FFFF);
    send_fields(32'h3_0000, 32'h3_0000, 32'h1, 32'h0, 1'b0, 1'b1);
    send_fields(32'h0, 32'h0, 32'h1, 32'h0, 1'b0, 1'b1);
    send_fields(32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
  endtask

  task automatic test_random_steps();
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_step(pick_step(p));
      run_random_rows(230);
    end
  endtask

  task automatic test_output_backpressure();
    point_item_t it;
    fork
      begin
        out_hold <= 1'b1;
        repeat (1000) @(posedge clk_i);
        out_hold <= 1'b0;
      end
    join_none
    for (int i = 0; i < 30; i++) begin
      it = make_point(1'b0);
      it.last_item = i[0];
      send_item(it);
    end
  endtask

  task automatic test_pause_until_drained();
    run_random_rows(10);
    idle_input(1);
    while (exp_sums.size() != 0) @(posedge clk_i);
    run_random_rows(10);
  endtask

  task automatic test_calm_tail();
    calm <= 1'b1;
    wait_drained();
    write_step(pick_step(0));
    run_random_rows(250);
  endtask

  // result check and receiver stall pattern
  always @(posedge clk_i) begin : check_sums
    logic [SUM_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_sums.size() == 0) begin
        $error("error_sum: expected none, actual %h", error_sum);
        fails++;
      end else begin
        want = exp_sums.pop_front();
        if (error_sum !== want) begin
          $error("error_sum: expected %h, actual %h", want, error_sum);
          fails++;
        end
      end
    end
    if (out_hold) begin
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 1) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 16);
    end else begin
      out_stall  <= 1'b0;
      stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 16);
    end
  end

  initial begin
    fails       = 0;
    stall_left  = 0;
    guard       = 0;
    step_model  = '0;
    sum_model   = '0;
    calm        <= 1'b0;
    out_hold    <= 1'b0;
    out_stall   <= 1'b0;
    rst_n       <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid    <= 1'b0;
    dist_now    <= '0;
    dist_goal   <= '0;
    own_coord   <= '0;
    other_coord <= '0;
    skip_item   <= 1'b0;
    last_item   <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_reset_step();
    test_step_extremes();
    test_root_truncation();
    test_random_steps();
    test_output_backpressure();
    test_pause_until_drained();
    test_calm_tail();

    idle_input(1);
    while (exp_sums.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (2 * ROOT_LAT) @(posedge clk_i);
    if (exp_sums.size() != 0) begin
      $error("error_sum: %0d expected results never arrived", exp_sums.size());
      fails++;
    end
    if (fails == 0) begin
      $display("perturbed_distance_error_sum_unit: match");
    end else begin
      $display("perturbed_distance_error_sum_unit: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
